FILE: design/rgbfb_pkg.sv
package rgbfb_pkg;

	localparam int PIXEL_COUNT = 64;
	localparam int PIX_AW      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int ENTRY_W     = 25;   // {on, green, red, blue}
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [2:0] {
		OP_SET    = 3'd0,
		OP_RESET  = 3'd1,
		OP_TOGGLE = 3'd2,
		OP_SHOW   = 3'd3,
		OP_OFF    = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_INVERT = 3'd6,
		OP_FILL   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGL,
		ST_SHOW,
		ST_FIND,
		ST_SWEEP,
		ST_FILL
	} state_t;

	// tag of the read issued to the pixel RAM, travels with the read data
	typedef enum logic [2:0] {
		RK_NONE,
		RK_TOGGLE,
		RK_SHOW,
		RK_FIND,
		RK_SWEEP
	} rd_kind_t;

	typedef struct packed {
		logic       on;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} pixel_t;

endpackage

FILE: design/rgbfb_ram.sv
module rgbfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: design/rgb_led_frame_buffer_engine_unit.sv
// Frame buffer for a strip of addressable RGB pixels.
// Input channel s_axis: one command per transfer (set, reset, toggle, show, off,
// clear on bits, invert, fill range). Output channel m_axis: one 24-bit
// green-red-blue word per pixel for show and off, pixel 0 first, tlast on the
// final pixel. Pixels that are off are sent as black.
// Commands use the single read port and single write port of the pixel RAM (one
// pixel per cycle, the show sweep pausing while the output buffer is full):
//   set, reset: a single write; toggle: read, then write back
//   show, off: read sweep, each word passing the RAM read register and the out register
//   clear on bits, fill: read-modify-write sweep / write sweep
//   invert: search for the first lit pixel plus a read-modify-write sweep
// s_axis_tready is high whenever no command is in progress; a new command is
// taken while show words still wait in the output buffer.
// Reset clears per-pixel valid flags at once, so every pixel reads black and off;
// no clearing pass is needed. Off clears the same flags together, with no sweep.
// When the receiver stalls, a two-entry output buffer fills and the show read
// sweep pauses until there is room; no word is dropped or repeated.
module rgb_led_frame_buffer_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] op, [12:3] position, [22:13] range_start, [32:23] range_stop,
	// [40:33] red_level, [48:41] green_level, [56:49] blue_level, [63:57] zero
	input  logic [rgbfb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [23:0] grb_word
	output logic [rgbfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic        m_axis_tlast   // last_pixel
);

	localparam int AW = rgbfb_pkg::PIX_AW;
	localparam logic [AW-1:0] LAST_IDX = AW'(rgbfb_pkg::PIXEL_COUNT - 1);
	localparam logic [9:0]    PIX_CNT10 = 10'(rgbfb_pkg::PIXEL_COUNT);

	// input fields
	rgbfb_pkg::op_t in_op;
	logic [9:0]     in_position;
	logic [9:0]     in_range_start;
	logic [9:0]     in_range_stop;
	logic [7:0]     in_red;
	logic [7:0]     in_green;
	logic [7:0]     in_blue;

	assign in_op          = rgbfb_pkg::op_t'(s_axis_tdata[2:0]);
	assign in_position    = s_axis_tdata[12:3];
	assign in_range_start = s_axis_tdata[22:13];
	assign in_range_stop  = s_axis_tdata[32:23];
	assign in_red         = s_axis_tdata[40:33];
	assign in_green       = s_axis_tdata[48:41];
	assign in_blue        = s_axis_tdata[56:49];

	rgbfb_pkg::state_t   state_q, state_d;
	rgbfb_pkg::rd_kind_t rd_kind, rd_kind_s1;
	rgbfb_pkg::op_t      op_q;

	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] rd_addr, addr_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	rgbfb_pkg::pixel_t wr_data;
	rgbfb_pkg::pixel_t ram_rd;
	rgbfb_pkg::pixel_t rd_pix;
	rgbfb_pkg::pixel_t color_q, color_d;
	logic [9:0]    start_q, stop_q;
	logic          vld_clr;
	logic [rgbfb_pkg::PIXEL_COUNT-1:0] vld_q;
	logic          vld_s1;
	logic          accept;
	logic          pos_ok;
	logic [AW-1:0] pos_addr;
	logic          in_range;

	// output buffer: out register plus skid entry
	logic        out_valid_q, skid_valid_q;
	logic [23:0] out_word_q, skid_word_q;
	logic        out_last_q, skid_last_q;
	logic        push, pop;
	logic [23:0] push_word;
	logic        push_last;
	logic [1:0]  occ, occ_left;
	logic        credit_ok;

	assign s_axis_tready = (state_q == rgbfb_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign pos_ok        = in_position < PIX_CNT10;
	assign pos_addr      = in_position[AW-1:0];
	assign in_range      = ({{(10-AW){1'b0}}, idx_q} >= start_q) &&
	                       ({{(10-AW){1'b0}}, idx_q} <= stop_q);

	rgbfb_ram #(
		.WIDTH (rgbfb_pkg::ENTRY_W),
		.DEPTH (rgbfb_pkg::PIXEL_COUNT)
	) u_pix_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// never-written entries read as black and off
	assign rd_pix = vld_s1 ? ram_rd : '0;

	// show words: stream buffer bookkeeping
	assign push      = (rd_kind_s1 == rgbfb_pkg::RK_SHOW);
	assign pop       = out_valid_q & m_axis_tready;
	assign push_word = rd_pix.on ? {rd_pix.green, rd_pix.red, rd_pix.blue} : 24'd0;
	assign push_last = (addr_s1 == LAST_IDX);
	assign occ       = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, push};
	assign occ_left  = occ - {1'b0, pop};
	assign credit_ok = occ_left < 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rgbfb_pkg::ST_IDLE;
			rd_kind_s1 <= rgbfb_pkg::RK_NONE;
			idx_q      <= '0;
			vld_q      <= '0;
		end else begin
			state_q    <= state_d;
			rd_kind_s1 <= rd_kind;
			idx_q      <= idx_d;
			if (vld_clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		vld_s1  <= vld_q[rd_addr];
		color_q <= color_d;
		if (accept) begin
			op_q    <= in_op;
			start_q <= in_range_start;
			stop_q  <= in_range_stop;
		end
	end

	// command sequencer
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		rd_kind = rgbfb_pkg::RK_NONE;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		vld_clr = 1'b0;
		color_d = color_q;
		case (state_q)
			rgbfb_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_op)
						rgbfb_pkg::OP_SET: begin
							if (pos_ok) begin
								wr_en   = 1'b1;
								wr_addr = pos_addr;
								wr_data = {(|{in_red, in_green, in_blue}),
								           in_green, in_red, in_blue};
							end
						end
						rgbfb_pkg::OP_RESET: begin
							if (pos_ok) begin
								wr_en   = 1'b1;
								wr_addr = pos_addr;
							end
						end
						rgbfb_pkg::OP_TOGGLE: begin
							if (pos_ok) begin
								rd_kind = rgbfb_pkg::RK_TOGGLE;
								rd_addr = pos_addr;
								state_d = rgbfb_pkg::ST_TGL;
							end
						end
						rgbfb_pkg::OP_SHOW: begin
							idx_d   = '0;
							state_d = rgbfb_pkg::ST_SHOW;
						end
						rgbfb_pkg::OP_OFF: begin
							vld_clr = 1'b1;
							idx_d   = '0;
							state_d = rgbfb_pkg::ST_SHOW;
						end
						rgbfb_pkg::OP_CLEAR: begin
							idx_d   = '0;
							state_d = rgbfb_pkg::ST_SWEEP;
						end
						rgbfb_pkg::OP_INVERT: begin
							idx_d   = '0;
							color_d = '0;
							state_d = rgbfb_pkg::ST_FIND;
						end
						rgbfb_pkg::OP_FILL: begin
							idx_d   = '0;
							color_d = {1'b1, in_green, in_red, in_blue};
							state_d = rgbfb_pkg::ST_FILL;
						end
						default: begin
							state_d = rgbfb_pkg::ST_IDLE;
						end
					endcase
				end
			end
			rgbfb_pkg::ST_TGL: begin
				wr_en   = 1'b1;
				wr_addr = addr_s1;
				wr_data = {~rd_pix.on, rd_pix.green, rd_pix.red, rd_pix.blue};
				state_d = rgbfb_pkg::ST_IDLE;
			end
			rgbfb_pkg::ST_FILL: begin
				wr_en   = in_range;
				wr_data = {1'b1, color_q.green, color_q.red, color_q.blue};
				if (idx_q == LAST_IDX) begin
					state_d = rgbfb_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			rgbfb_pkg::ST_SHOW: begin
				if (credit_ok) begin
					rd_kind = rgbfb_pkg::RK_SHOW;
					if (idx_q == LAST_IDX) begin
						state_d = rgbfb_pkg::ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			rgbfb_pkg::ST_FIND: begin
				// stream reads; stop at the first lit pixel or after the last one
				rd_kind = rgbfb_pkg::RK_FIND;
				if (idx_q != LAST_IDX) begin
					idx_d = idx_q + 1'b1;
				end
				if (rd_kind_s1 == rgbfb_pkg::RK_FIND) begin
					if (rd_pix.on) begin
						color_d = rd_pix;
						idx_d   = '0;
						state_d = rgbfb_pkg::ST_SWEEP;
					end else if (addr_s1 == LAST_IDX) begin
						idx_d   = '0;
						state_d = rgbfb_pkg::ST_SWEEP;
					end
				end
			end
			rgbfb_pkg::ST_SWEEP: begin
				// read pixel i while writing back pixel i-1
				rd_kind = rgbfb_pkg::RK_SWEEP;
				if (idx_q != LAST_IDX) begin
					idx_d = idx_q + 1'b1;
				end
				if (rd_kind_s1 == rgbfb_pkg::RK_SWEEP) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1;
					if (op_q == rgbfb_pkg::OP_CLEAR) begin
						wr_data = {1'b0, rd_pix.green, rd_pix.red, rd_pix.blue};
					end else if (rd_pix.on) begin
						wr_data = '0;
					end else begin
						wr_data = {1'b1, color_q.green, color_q.red, color_q.blue};
					end
					if (addr_s1 == LAST_IDX) begin
						state_d = rgbfb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rgbfb_pkg::ST_IDLE;
			end
		endcase
	end

	// output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_word_q <= skid_word_q;
				out_last_q <= skid_last_q;
				if (push) begin
					skid_word_q <= push_word;
					skid_last_q <= push_last;
				end
			end else if (push) begin
				out_word_q <= push_word;
				out_last_q <= push_last;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_word_q <= push_word;
				skid_last_q <= push_last;
			end else begin
				out_word_q <= push_word;
				out_last_q <= push_last;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a word while the out register is empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !pop) |-> !skid_valid_q)
		else $error("show word arrived with the output buffer full");

	a_toggle_read_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_kind_s1 == rgbfb_pkg::RK_TOGGLE) |-> (state_q == rgbfb_pkg::ST_TGL))
		else $error("toggle read data with no toggle write-back pending");

	a_show_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbfb_pkg::ST_SHOW) |-> !wr_en)
		else $error("pixel RAM written during a show sweep");

endmodule
